FILE: sv/srp_pkg.sv
// Package: shared constants, codes and the command word type of the packetizer.
`default_nettype none
package srp_pkg;

  localparam int BUF_DEPTH   = 64;
  localparam int BURST_BYTES = 16;
  localparam int Q_DEPTH     = 4;

  localparam int IDX_W   = $clog2(BUF_DEPTH);
  localparam int FILL_W  = $clog2(BUF_DEPTH + 1);
  localparam int CNT_W   = (FILL_W > 6) ? FILL_W : 6;
  localparam int ACK_ROOM = BUF_DEPTH - BURST_BYTES - 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);
  localparam int NSLOT   = 7;

  localparam logic [7:0] CODE_ETX = 8'h03;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_ENQ = 8'h05;
  localparam logic [7:0] CODE_ACK = 8'h06;
  localparam logic [7:0] CHR_V    = 8'h56;
  localparam logic [7:0] CHR_1    = 8'h31;
  localparam logic [7:0] CHR_DOT  = 8'h2E;
  localparam logic [7:0] CHR_0    = 8'h30;

  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [1:0] CFG_NODE_ADDR   = 2'd1;

  localparam logic       KIND_SERIAL = 1'b0;
  localparam logic       KIND_TICK   = 1'b1;

  localparam logic [1:0] DEST_RADIO  = 2'd0;
  localparam logic [1:0] DEST_SERIAL = 2'd1;
  localparam logic [1:0] DEST_STROBE = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_HDR  = 2'd1,
    OP_DATA = 2'd2,
    OP_STB  = 2'd3
  } pk_op_t;

  typedef enum logic [2:0] {
    PK_IDLE = 3'b001,
    PK_COPY = 3'b010,
    PK_SEND = 3'b100
  } pk_state_t;

  // One tick's worth of work for the back end.
  typedef struct packed {
    logic       ack;
    logic       ver;
    pk_op_t     op;
    logic [7:0] b0;
    logic [7:0] b1;
  } cmd_t;

endpackage
`default_nettype wire

FILE: sv/srp_front.sv
// Front end: word intake, ring store, flags, packetizer state and tick commands.
`default_nettype none
module srp_front
  import srp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_radio_busy,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             push,
  output cmd_t             push_data,
  input  wire logic        q_full
);

  logic [7:0]       ring_mem [BUF_DEPTH];
  logic [7:0]       rd_q;

  logic [IDX_W-1:0] widx_r, widx_nxt;
  logic [IDX_W-1:0] ridx_r, ridx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic             ack_r, ack_nxt;
  logic             end_r, end_nxt;
  logic             ver_r, ver_nxt;
  pk_state_t        pk_r, pk_nxt;
  logic [CNT_W-1:0] btc_r, btc_nxt;
  logic [5:0]       maxp_r;
  logic [7:0]       addr_r;

  logic             stg_vld_r, stg_vld_nxt;
  cmd_t             stg_cmd_r, stg_cmd_nxt;
  logic             stg_mem_r, stg_mem_nxt;

  logic             in_fire;
  logic             full;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] wr_addr;
  logic             ack_ok;
  cmd_t             cmd;
  logic             use_mem;

  assign in_stall = stg_vld_r && q_full;
  assign in_fire  = in_valid && !in_stall;
  assign push     = stg_vld_r && !q_full;
  assign full     = (fill_r == FILL_W'(BUF_DEPTH));
  assign ack_ok   = (ACK_ROOM > 0) && (fill_r < FILL_W'(ACK_ROOM));
  assign wr_addr  = full ? ((widx_r == '0) ? IDX_W'(BUF_DEPTH - 1) : widx_r - 1'b1) : widx_r;

  always_comb begin
    push_data = stg_cmd_r;
    if (stg_mem_r) begin
      push_data.b0 = rd_q;
    end
  end

  always_comb begin
    widx_nxt    = widx_r;
    ridx_nxt    = ridx_r;
    fill_nxt    = fill_r;
    ack_nxt     = ack_r;
    end_nxt     = end_r;
    ver_nxt     = ver_r;
    pk_nxt      = pk_r;
    btc_nxt     = btc_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    use_mem     = 1'b0;
    cmd         = '{ack: 1'b0, ver: 1'b0, op: OP_NONE, b0: 8'h00, b1: addr_r};
    stg_vld_nxt = push ? 1'b0 : stg_vld_r;
    stg_cmd_nxt = stg_cmd_r;
    stg_mem_nxt = stg_mem_r;

    if (in_fire && in_kind == KIND_SERIAL) begin
      if (in_data_byte == CODE_ETX) begin
        ack_nxt = 1'b1;
      end else if (in_data_byte == CODE_ENQ) begin
        ver_nxt = 1'b1;
      end else if (!end_r) begin
        mem_we = 1'b1;
        // full ring: newest byte is replaced, indices and count hold
        if (!full) begin
          widx_nxt = (widx_r == IDX_W'(BUF_DEPTH - 1)) ? '0 : widx_r + 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
        if (in_data_byte == CODE_EOT) begin
          end_nxt = 1'b1;
        end
      end
    end

    if (in_fire && in_kind == KIND_TICK) begin
      if (ack_r && ack_ok) begin
        ack_nxt = 1'b0;
        cmd.ack = 1'b1;
      end
      if (ver_r) begin
        ver_nxt = 1'b0;
        cmd.ver = 1'b1;
      end
      if (!in_radio_busy) begin
        unique case (pk_r)
          PK_COPY: begin
            if (btc_r != '0) begin
              cmd.op  = OP_DATA;
              btc_nxt = btc_r - 1'b1;
              if (fill_r != '0) begin
                mem_re   = 1'b1;
                use_mem  = 1'b1;
                ridx_nxt = (ridx_r == IDX_W'(BUF_DEPTH - 1)) ? '0 : ridx_r + 1'b1;
                fill_nxt = fill_r - 1'b1;
              end
            end else begin
              pk_nxt = PK_SEND;
            end
          end
          PK_SEND: begin
            cmd.op = OP_STB;
            pk_nxt = PK_IDLE;
          end
          PK_IDLE: begin
            if (end_r) begin
              end_nxt = 1'b0;
              btc_nxt = CNT_W'(fill_r);
              cmd.op  = OP_HDR;
              cmd.b0  = 8'(fill_r) + 8'd1;
              pk_nxt  = PK_COPY;
            end else if (CNT_W'(fill_r) >= CNT_W'(maxp_r)) begin
              btc_nxt = CNT_W'(maxp_r);
              cmd.op  = OP_HDR;
              cmd.b0  = 8'(maxp_r) + 8'd1;
              pk_nxt  = PK_COPY;
            end
          end
          default: pk_nxt = PK_IDLE;
        endcase
      end
      if (cmd.ack || cmd.ver || cmd.op != OP_NONE) begin
        stg_vld_nxt = 1'b1;
        stg_cmd_nxt = cmd;
        stg_mem_nxt = use_mem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= in_data_byte;
    end
    if (mem_re) begin
      rd_q <= ring_mem[ridx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r    <= '0;
      ridx_r    <= '0;
      fill_r    <= '0;
      ack_r     <= 1'b0;
      end_r     <= 1'b0;
      ver_r     <= 1'b0;
      pk_r      <= PK_IDLE;
      btc_r     <= '0;
      maxp_r    <= 6'd46;
      addr_r    <= 8'h00;
      stg_vld_r <= 1'b0;
    end else begin
      widx_r    <= widx_nxt;
      ridx_r    <= ridx_nxt;
      fill_r    <= fill_nxt;
      ack_r     <= ack_nxt;
      end_r     <= end_nxt;
      ver_r     <= ver_nxt;
      pk_r      <= pk_nxt;
      btc_r     <= btc_nxt;
      stg_vld_r <= stg_vld_nxt;
      if (cfg_we && cfg_index == CFG_MAX_PAYLOAD) begin
        maxp_r <= cfg_data[5:0];
      end
      if (cfg_we && cfg_index == CFG_NODE_ADDR) begin
        addr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_cmd_r <= stg_cmd_nxt;
    stg_mem_r <= stg_mem_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BUF_DEPTH))
    else $error("ring fill count above depth");

  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pk_r == PK_COPY) |-> (btc_r <= CNT_W'(fill_r)))
    else $error("copy count exceeds buffered bytes");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stg_vld_r && !push))
    else $error("stall without a blocked command");

endmodule
`default_nettype wire

FILE: sv/srp_queue.sv
// Command queue between the front end and the back end.
`default_nettype none
module srp_queue
  import srp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  push_data,
  output logic       q_full,
  input  wire logic  pop,
  output logic       q_vld,
  output cmd_t       q_data
);

  cmd_t             ent [Q_DEPTH];
  logic [QP_W-1:0]  wp_r, rp_r;
  logic [QC_W-1:0]  cnt_r;

  assign q_full = (cnt_r == QC_W'(Q_DEPTH));
  assign q_vld  = (cnt_r != '0);
  assign q_data = ent[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QP_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == QP_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/srp_back.sv
// Back end: expands queued commands into result words, one per cycle while out_stall is low.
`default_nettype none
module srp_back
  import srp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_vld,
  input  wire cmd_t        q_data,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_dest,
  output logic [7:0]       out_out_byte,
  output logic             out_last
);

  cmd_t             ent_r;
  logic [NSLOT-1:0] rem_r, rem_nxt;
  logic [NSLOT-1:0] low, rem_clr, load_mask;
  logic             adv, emit;
  logic             vld_r;
  logic [1:0]       dest_r, dest_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r;

  assign adv      = !vld_r || !out_stall;
  assign emit     = adv && (rem_r != '0);
  assign low      = rem_r & (~rem_r + 1'b1);
  assign rem_clr  = rem_r & ~low;
  assign pop      = q_vld && ((rem_r == '0) || (emit && rem_clr == '0));
  // slots: ack, four version chars, packer byte or strobe, address byte
  assign load_mask = {q_data.op == OP_HDR, q_data.op != OP_NONE,
                      {4{q_data.ver}}, q_data.ack};

  assign out_valid    = vld_r;
  assign out_dest     = dest_r;
  assign out_out_byte = byte_r;
  assign out_last     = last_r;

  always_comb begin
    dest_nxt = DEST_SERIAL;
    byte_nxt = 8'h00;
    unique case (low)
      7'b0000001: byte_nxt = CODE_ACK;
      7'b0000010: byte_nxt = CHR_V;
      7'b0000100: byte_nxt = CHR_1;
      7'b0001000: byte_nxt = CHR_DOT;
      7'b0010000: byte_nxt = CHR_0;
      7'b0100000: begin
        if (ent_r.op == OP_STB) begin
          dest_nxt = DEST_STROBE;
        end else begin
          dest_nxt = DEST_RADIO;
          byte_nxt = ent_r.b0;
        end
      end
      7'b1000000: begin
        dest_nxt = DEST_RADIO;
        byte_nxt = ent_r.b1;
      end
      default: begin
        dest_nxt = DEST_SERIAL;
        byte_nxt = 8'h00;
      end
    endcase
  end

  always_comb begin
    rem_nxt = emit ? rem_clr : rem_r;
    if (pop) begin
      rem_nxt = load_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      vld_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      if (adv) begin
        vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= q_data;
    end
    if (emit) begin
      dest_r <= dest_nxt;
      byte_r <= byte_nxt;
      last_r <= (rem_clr == '0);
    end
  end

  a_more_left: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !last_r) |-> (rem_r != '0))
    else $error("non-final word with nothing left to send");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !emit) |-> (rem_r == '0))
    else $error("command loaded over unfinished work");

  a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> $onehot(low))
    else $error("slot select not one-hot");

endmodule
`default_nettype wire

FILE: sv/serial_to_radio_packetizer_unit.sv
// Top level: serial-to-radio packetizer, front end, command queue and back end.
//
// Serial words (kind 0) steer the block: ETX raises an ack request, ENQ a version
// request, and other bytes enter a 64-byte ring store (EOT is stored and marks the
// end of a message; bytes after it are dropped until a packet starts; a full ring
// replaces its newest byte). Poll ticks (kind 1) produce 0 to 7 result words: ACK on
// the serial line when asked and the ring has more than BURST_BYTES+2 free slots, the
// version string "V1.0", then one packetizer step unless radio_busy (a length byte
// and the address, one payload byte, or the transmit strobe). last marks the final
// word of a tick. A taken tick's command goes into a staging register (the ring read
// is registered alongside it), then into a 4-entry queue; while the queue is full the
// command waits in staging. The back end loads it and sends one result word per
// cycle while out_stall is low, loading the next command in the cycle that sends the
// last word of the current one; a tick with no result words puts nothing in the
// queue. The input side keeps taking words while the queue or its staging register
// has room, independent of out_stall. The ring store holds no reset; only written
// entries are ever read. Configuration (max_payload at index 0, the device address
// at index 1) must be written while the block is idle.
`default_nettype none
module serial_to_radio_packetizer_unit
  import srp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_kind,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_radio_busy,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_dest,
  output logic [7:0]       out_out_byte,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  logic push, q_full, pop, q_vld;
  cmd_t push_data, q_data;

  // intake, ring store and packetizer state
  srp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_data_byte  (in_data_byte),
    .in_radio_busy (in_radio_busy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  // decouples tick intake from output back-pressure
  srp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full),
    .pop       (pop),
    .q_vld     (q_vld),
    .q_data    (q_data)
  );

  // serializer with registered output
  srp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_vld),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_dest     (out_dest),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

endmodule
`default_nettype wire
